### rtl/assert_macros.svh
// Assertion macros for the RTL of the search-or-append table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define SAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication with the consequent checked in the cycle after the condition.
`define SAT_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/sat_pkg.sv
package sat_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_APPEND = 2'd0;
    localparam t_mode MODE_SEARCH = 2'd1;
    localparam t_mode MODE_LIST   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_FOUND    = 3'd1,
        ST_INSERTED = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [POS_W-1:0]     position;
        logic [VALUE_W-1:0]   entry_value;
        logic                 last;
    } t_result;

endpackage

### rtl/sat_mem.sv
module sat_mem
    import sat_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = DATA_WIDTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data only changes when a read is issued, so it holds during a stall.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sat_obuf.sv
module sat_obuf
    import sat_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_push_ready,
    output logic    o_tvalid,
    input  logic    i_tready,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_data;

    assign o_push_ready = !r_valid || i_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_push && o_push_ready) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_push_ready) begin
            r_data <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_result = r_data;

endmodule

### rtl/sat_ctrl.sv
`include "assert_macros.svh"

module sat_ctrl
    import sat_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int SW    = DATA_WIDTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_mode              i_mode,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [SW-1:0]      o_wdata,
    output logic               o_re,
    output logic [AW-1:0]      o_raddr,
    input  logic [SW-1:0]      i_rdata,
    output logic               o_push,
    input  logic               i_push_ready,
    output t_result            o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LIST = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_key, n_key;
    t_result       r_res, n_res;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          idx_last;
    logic [SW-1:0] key_in;
    t_result       list_res;

    assign accept   = i_valid && o_ready;
    assign is_full  = (r_fill == CW'(DEPTH));
    assign is_empty = (r_fill == '0);
    assign idx_last = ((CW'(r_idx) + CW'(1)) == r_fill);
    assign key_in   = i_value[SW-1:0];

    assign list_res = '{status: ST_FOUND, position: POS_W'(r_idx),
                        entry_value: VALUE_W'(i_rdata), last: idx_last};

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_key    = r_key;
        n_res    = r_res;
        o_ready  = (r_state == S_IDLE);
        o_we     = 1'b0;
        o_waddr  = r_fill[AW-1:0];
        o_wdata  = r_key;
        o_re     = 1'b0;
        o_raddr  = r_idx + AW'(1);
        o_push   = 1'b0;
        o_result = r_res;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key = key_in;
                    case (i_mode)
                        MODE_APPEND: begin
                            n_state = S_EMIT;
                            if (is_full) begin
                                n_res = '{ST_FULL, '0, '0, 1'b1};
                            end else begin
                                o_we    = 1'b1;
                                o_wdata = key_in;
                                n_fill  = r_fill + CW'(1);
                                n_res   = '{ST_APPENDED, POS_W'(r_fill),
                                            VALUE_W'(key_in), 1'b1};
                            end
                        end
                        MODE_SEARCH, MODE_LIST: begin
                            if (is_empty) begin
                                n_state = S_EMIT;
                                n_res   = '{ST_EMPTY, '0, '0, 1'b1};
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = '0;
                                n_idx   = '0;
                                n_state = (i_mode == MODE_SEARCH) ? S_SCAN : S_LIST;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // The read data belongs to entry r_idx; the next read overlaps the compare.
                if (i_rdata == r_key) begin
                    n_state = S_EMIT;
                    n_res   = '{ST_FOUND, POS_W'(r_idx), VALUE_W'(i_rdata), 1'b1};
                end else if (idx_last) begin
                    n_state = S_EMIT;
                    if (is_full) begin
                        n_res = '{ST_FULL, '0, '0, 1'b1};
                    end else begin
                        o_we   = 1'b1;
                        n_fill = r_fill + CW'(1);
                        n_res  = '{ST_INSERTED, POS_W'(r_fill), VALUE_W'(r_key), 1'b1};
                    end
                end else begin
                    o_re  = 1'b1;
                    n_idx = r_idx + AW'(1);
                end
            end
            S_LIST: begin
                o_push   = 1'b1;
                o_result = list_res;
                if (i_push_ready) begin
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_re  = 1'b1;
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_EMIT: begin
                o_push = 1'b1;
                if (i_push_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_key <= n_key;
        r_res <= n_res;
    end

    `SAT_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= CW'(DEPTH),
        "fill count beyond table depth")
    `SAT_ASSERT(a_no_write_full, i_clk, i_rst_n, !o_we || !is_full,
        "write issued to a full table")
    `SAT_ASSERT_NEXT(a_write_counts, i_clk, i_rst_n, o_we,
        r_fill == $past(r_fill) + CW'(1), "write did not advance the fill count")
    `SAT_ASSERT_NEXT(a_list_ends, i_clk, i_rst_n,
        o_push && i_push_ready && o_result.last, r_state == S_IDLE,
        "final result pushed but sequencer not idle")

endmodule

### rtl/search_or_append_table.sv
// Search-or-append table: an ordered store of values kept in insertion order.
// Commands arrive as items on the slave stream; tuser carries the mode
// (0 append, 1 search and append if absent, 2 list all, 3 ignored) and tdata
// the value or key. Results leave on the master stream; tuser carries the
// status, tdata the position and the entry value, and tlast marks the final
// result of a command.
// An append's result is registered in the sequencer, then in the output
// register. A search reads one stored entry per cycle from the table memory;
// a listing delivers one entry per cycle while the receiver does not stall.
// The table memory has a single read port; one command is worked on at a time.
// A new item is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register. When the receiver stalls, the
// output register holds its item and a listing pauses until it drains.
// Reset empties the table at once by clearing the fill count; the memory
// itself is not cleared, as entries at or above the fill count are never read.
module search_or_append_table
    import sat_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // value[31:0]
    input  logic [1:0]  i_s_axis_tuser,  // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // position[5:0], entry_value[37:6], zero[39:38]
    output logic [2:0]  o_m_axis_tuser,  // status[2:0]
    output logic        o_m_axis_tlast
);

    // Values are stored and compared in their low DATA_WIDTH bits, at most 32.
    localparam int SW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [SW-1:0] mem_rdata;

    logic    push;
    logic    push_ready;
    t_result push_res;
    t_result out_res;

    sat_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sat_ctrl #(
        .DEPTH (DEPTH),
        .SW    (SW),
        .AW    (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_mode       (i_s_axis_tuser),
        .i_value      (i_s_axis_tdata),
        .o_we         (mem_we),
        .o_waddr      (mem_waddr),
        .o_wdata      (mem_wdata),
        .o_re         (mem_re),
        .o_raddr      (mem_raddr),
        .i_rdata      (mem_rdata),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_result     (push_res)
    );

    // Output register: parts the sequencer from a stalling receiver.
    sat_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_result     (push_res),
        .o_push_ready (push_ready),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_result     (out_res)
    );

    assign o_m_axis_tdata = {2'b00, out_res.entry_value, out_res.position};
    assign o_m_axis_tuser = out_res.status;
    assign o_m_axis_tlast = out_res.last;

endmodule
